/* rtl/box_mean_subtract_filter_assert.svh */
// Assertion macros for the box mean subtract filter.
`ifndef BOX_MEAN_SUBTRACT_FILTER_ASSERT_SVH
`define BOX_MEAN_SUBTRACT_FILTER_ASSERT_SVH
`ifndef SYNTH
`define BMSF_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BMSF_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define BMSF_ASSERT_IMP(label, clk, rst_n, a, c)
`define BMSF_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/bmsf_pkg.sv */
package bmsf_pkg;

	typedef struct packed {
		logic       func;
		logic [6:0] row;
		logic [6:0] col;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
		logic       status;
	} out_word_t;

	typedef enum logic [1:0] {
		REG_FRAME_ROWS = 2'd0,
		REG_FRAME_COLS = 2'd1,
		REG_RADIUS     = 2'd2,
		REG_HAS_ALPHA  = 2'd3
	} reg_idx_t;

	localparam logic       FUNC_LOAD  = 1'b0;
	localparam logic [9:0] INV_FULL   = 10'd765;
	localparam logic [9:0] DARK_LIMIT = 10'd100;
	localparam logic [7:0] OPAQUE     = 8'd255;

endpackage

/* rtl/bmsf_div.sv */
// Restoring divider, one quotient bit per cycle.
module bmsf_div #(
	parameter int NW = 32,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   trial;

	assign trial = {rem_q, quo_q[NW-1]};
	assign busy  = (cnt_q != '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (trial >= {{(NW+1-DW){1'b0}}, den_q}) begin
				rem_q <= NW'(trial - {{(NW+1-DW){1'b0}}, den_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	`include "box_mean_subtract_filter_assert.svh"
	`BMSF_ASSERT_NXT(a_div_count, clk, arst_n, start, cnt_q == CW'(NW))
	`BMSF_ASSERT_NXT(a_div_dec, clk, arst_n, busy && !start, cnt_q == $past(cnt_q) - 1'b1)
	`BMSF_ASSERT_IMP(a_div_idle, clk, arst_n, !busy, cnt_q == '0)
endmodule

/* rtl/box_mean_subtract_filter.sv */
// Box mean subtract filter.
// Input words arrive on in_valid/in_stall with payload in_data. A load word
// (func 0) stores the next raster pixel and extends the summed-area table of
// inverted intensity; it produces no output word. A query word (func 1)
// returns one word on out_valid/out_stall: each colour channel minus the
// integer mean of inverted intensity over the clipped window, floored at
// zero, with error status for an incomplete frame or an outside position.
// A load reads the row above from the table, then writes the new entry, then
// returns to idle for the next word. A valid query runs a setup step, a read
// and an accumulate step for each of four corners from the single table port,
// a divider start step, a wait on the 32-step serial divider, then an output
// step. An error query goes straight to the output step. After the result is
// loaded the block returns to idle to take the next word.
// in_stall is high while the block works and during a configuration write.
// A stalled result stays in the output register, and a finished query waits
// there for it, which holds off the input.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data, only while idle; a frame size write restarts loading.
// Reset clears control state and registers; the stores hold garbage until
// a full frame is loaded, and queries before that return an error.
module box_mean_subtract_filter #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bmsf_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bmsf_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CW   = $clog2(MAX_COLS);
	localparam int RWX  = (RW < 1) ? 1 : RW;
	localparam int CWX  = (CW < 1) ? 1 : CW;
	localparam int AW   = RWX + CWX;
	localparam int DEP  = MAX_ROWS * (2 ** CWX);
	localparam int SW   = 32;
	localparam int ARW  = 22;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LD_RD, ST_LD_WR, ST_Q_SETUP, ST_Q_RD, ST_Q_ACC, ST_Q_DIV,
		ST_Q_WAIT, ST_Q_OUT
	} state_t;

	state_t state_q;
	logic [7:0] rows_cfg_q, cols_cfg_q;
	logic [6:0] radius_q;
	logic       has_alpha_q;
	logic [10:0] ld_r_q, ld_c_q;
	logic        loaded_q;
	logic [16:0] row_sum_q;
	logic [23:0] tab_mem [DEP];
	logic [31:0] pix_mem [DEP];
	logic [23:0] tab_rd_q;
	logic [31:0] pix_rd_q;
	logic [AW-1:0] raddr;
	logic [1:0]  corner_q;
	logic [2:0]  rd_cnt_q;
	logic [SW-1:0] sum_q;
	logic [ARW-1:0] area_q;
	logic [10:0] li_q, hi_q, lj_q, hj_q;
	logic [6:0]  qr_q, qc_q;
	logic [9:0]  avg_q;
	logic        err_q;
	bmsf_pkg::out_word_t res_q;
	logic        div_start;
	logic        div_busy;
	logic [SW-1:0] div_quo;
	logic [10:0] rows_eff, cols_eff;
	logic [9:0]  bgr;
	logic [16:0] row_sum_nx;
	logic        out_load;

	always_comb begin
		if (rows_cfg_q == 8'd0) rows_eff = 11'd1;
		else if ({3'd0, rows_cfg_q} > 11'(MAX_ROWS)) rows_eff = 11'(MAX_ROWS);
		else rows_eff = {3'd0, rows_cfg_q};
		if (cols_cfg_q == 8'd0) cols_eff = 11'd1;
		else if ({3'd0, cols_cfg_q} > 11'(MAX_COLS)) cols_eff = 11'(MAX_COLS);
		else cols_eff = {3'd0, cols_cfg_q};
	end

	assign bgr = 10'(in_data.blue) + 10'(in_data.green) + 10'(in_data.red);
	assign row_sum_nx = ((ld_c_q == '0) ? 17'd0 : row_sum_q)
		+ 17'(bmsf_pkg::INV_FULL - bgr);
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_data  = res_q;
	assign div_start = (state_q == ST_Q_DIV);
	// The output register takes a new word once the previous one has left or is leaving.
	assign out_load  = (state_q == ST_Q_OUT) && (!out_valid || !out_stall);

	// Table read address: row above on load, current corner on query.
	logic [10:0] cr, cc;
	always_comb begin
		cr = '0;
		cc = '0;
		if (state_q == ST_IDLE || state_q == ST_LD_RD) begin
			cr = ld_r_q - 11'd1;
			cc = ld_c_q;
		end else begin
			case (corner_q)
				2'd0: begin cr = hi_q; cc = hj_q; end
				2'd1: begin cr = li_q - 11'd1; cc = hj_q; end
				2'd2: begin cr = hi_q; cc = lj_q - 11'd1; end
				default: begin cr = li_q - 11'd1; cc = lj_q - 11'd1; end
			endcase
		end
		raddr = {cr[RWX-1:0], cc[CWX-1:0]};
	end

	logic [AW-1:0] waddr;
	assign waddr = {ld_r_q[RWX-1:0], ld_c_q[CWX-1:0]};
	logic [16:0] ld_sum_q;
	logic [7:0] ld_b_q, ld_g_q, ld_r8_q, ld_a_q;

	always_ff @(posedge clk) begin
		tab_rd_q <= tab_mem[raddr];
		pix_rd_q <= pix_mem[{RWX'(qr_q), CWX'(qc_q)}];
		if (state_q == ST_LD_WR) begin
			tab_mem[waddr] <= 24'(ld_sum_q) + ((ld_r_q == '0) ? 24'd0 : tab_rd_q);
			pix_mem[waddr] <= {ld_a_q, ld_r8_q, ld_g_q, ld_b_q};
		end
	end

	logic corner_used;
	always_comb begin
		case (corner_q)
			2'd0: corner_used = 1'b1;
			2'd1: corner_used = (li_q != '0);
			2'd2: corner_used = (lj_q != '0);
			default: corner_used = (li_q != '0) && (lj_q != '0);
		endcase
	end

	logic [10:0] h_rows, w_cols;
	assign h_rows = hi_q - li_q + 11'd1;
	assign w_cols = hj_q - lj_q + 11'd1;

	// The mean can reach 765, so the channels are compared at 10 bits.
	logic [7:0] ob, og, orr, oa;
	always_comb begin
		ob  = ({2'd0, pix_rd_q[7:0]} > avg_q)
			? 8'({2'd0, pix_rd_q[7:0]} - avg_q) : 8'd0;
		og  = ({2'd0, pix_rd_q[15:8]} > avg_q)
			? 8'({2'd0, pix_rd_q[15:8]} - avg_q) : 8'd0;
		orr = ({2'd0, pix_rd_q[23:16]} > avg_q)
			? 8'({2'd0, pix_rd_q[23:16]} - avg_q) : 8'd0;
		oa  = has_alpha_q ? pix_rd_q[31:24] : bmsf_pkg::OPAQUE;
		if (10'(ob) + 10'(og) + 10'(orr) < bmsf_pkg::DARK_LIMIT) oa = bmsf_pkg::OPAQUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_cfg_q  <= 8'd128;
			cols_cfg_q  <= 8'd128;
			radius_q    <= 7'd1;
			has_alpha_q <= 1'b0;
			ld_r_q      <= '0;
			ld_c_q      <= '0;
			loaded_q    <= 1'b0;
			row_sum_q   <= '0;
			out_valid   <= 1'b0;
			corner_q    <= '0;
			rd_cnt_q    <= '0;
			ld_sum_q    <= '0;
			ld_b_q      <= '0;
			ld_g_q      <= '0;
			ld_r8_q     <= '0;
			ld_a_q      <= '0;
			qr_q        <= '0;
			qc_q        <= '0;
			err_q       <= 1'b0;
			res_q       <= '0;
			li_q        <= '0;
			hi_q        <= '0;
			lj_q        <= '0;
			hj_q        <= '0;
			sum_q       <= '0;
			area_q      <= '0;
			avg_q       <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (bmsf_pkg::reg_idx_t'(cfg_index))
							bmsf_pkg::REG_FRAME_ROWS: begin
								rows_cfg_q <= cfg_data;
								loaded_q <= 1'b0; ld_r_q <= '0; ld_c_q <= '0;
							end
							bmsf_pkg::REG_FRAME_COLS: begin
								cols_cfg_q <= cfg_data;
								loaded_q <= 1'b0; ld_r_q <= '0; ld_c_q <= '0;
							end
							bmsf_pkg::REG_RADIUS: radius_q <= cfg_data[6:0];
							default: has_alpha_q <= cfg_data[0];
						endcase
					end else if (in_valid) begin
						if (in_data.func == bmsf_pkg::FUNC_LOAD) begin
							if (loaded_q || ld_r_q >= rows_eff) begin
								loaded_q <= 1'b0;
								ld_r_q <= '0;
								ld_c_q <= '0;
								row_sum_q <= 17'(bmsf_pkg::INV_FULL - bgr);
								ld_sum_q  <= 17'(bmsf_pkg::INV_FULL - bgr);
							end else begin
								row_sum_q <= row_sum_nx;
								ld_sum_q  <= row_sum_nx;
							end
							ld_b_q <= in_data.blue;
							ld_g_q <= in_data.green;
							ld_r8_q <= in_data.red;
							ld_a_q <= in_data.alpha;
							state_q <= ST_LD_RD;
						end else begin
							qr_q <= in_data.row;
							qc_q <= in_data.col;
							if (!loaded_q || {4'd0, in_data.row} >= rows_eff
								|| {4'd0, in_data.col} >= cols_eff) begin
								err_q <= 1'b1;
								state_q <= ST_Q_OUT;
							end else begin
								err_q <= 1'b0;
								state_q <= ST_Q_SETUP;
							end
						end
					end
				end
				ST_LD_RD: state_q <= ST_LD_WR;
				ST_LD_WR: begin
					if (ld_c_q + 11'd1 >= cols_eff) begin
						ld_c_q <= '0;
						ld_r_q <= ld_r_q + 11'd1;
						if (ld_r_q + 11'd1 >= rows_eff) loaded_q <= 1'b1;
					end else begin
						ld_c_q <= ld_c_q + 11'd1;
					end
					state_q <= ST_IDLE;
				end
				ST_Q_SETUP: begin
					li_q <= (qr_q > radius_q) ? 11'(qr_q - radius_q) : 11'd0;
					lj_q <= (qc_q > radius_q) ? 11'(qc_q - radius_q) : 11'd0;
					hi_q <= (11'(qr_q) + 11'(radius_q) < rows_eff - 11'd1)
						? 11'(qr_q) + 11'(radius_q) : rows_eff - 11'd1;
					hj_q <= (11'(qc_q) + 11'(radius_q) < cols_eff - 11'd1)
						? 11'(qc_q) + 11'(radius_q) : cols_eff - 11'd1;
					corner_q <= '0;
					sum_q <= '0;
					state_q <= ST_Q_RD;
				end
				ST_Q_RD: begin
					if (rd_cnt_q == 3'd1) begin
						rd_cnt_q <= '0;
						state_q <= ST_Q_ACC;
					end else begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
				end
				ST_Q_ACC: begin
					if (corner_used) begin
						if (corner_q == 2'd1 || corner_q == 2'd2)
							sum_q <= sum_q - SW'(tab_rd_q);
						else
							sum_q <= sum_q + SW'(tab_rd_q);
					end
					if (corner_q == 2'd3) begin
						area_q <= ARW'(h_rows) * ARW'(w_cols);
						state_q <= ST_Q_DIV;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q <= ST_Q_RD;
					end
				end
				ST_Q_DIV: state_q <= ST_Q_WAIT;
				ST_Q_WAIT: begin
					if (!div_busy) begin
						avg_q <= sum_q[SW-1] ? 10'd0 : div_quo[9:0];
						state_q <= ST_Q_OUT;
					end
				end
				default: begin
					if (out_load) begin
						if (err_q) begin
							res_q <= '{out_blue: 8'd0, out_green: 8'd0, out_red: 8'd0,
								out_alpha: 8'd0, status: 1'b1};
						end else begin
							res_q <= '{out_blue: ob, out_green: og, out_red: orr,
								out_alpha: oa, status: 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	bmsf_div #(.NW(SW), .DW(ARW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (area_q),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	`include "box_mean_subtract_filter_assert.svh"
	`BMSF_ASSERT_IMP(a_idle_ready, clk, arst_n, state_q != ST_IDLE, !cfg_ready && in_stall)
	`BMSF_ASSERT_NXT(a_ld_wr, clk, arst_n, state_q == ST_LD_RD, state_q == ST_LD_WR)
	`BMSF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_q))
endmodule
